/* rtl/pstb_pkg.sv */
// Package for the pausable scaled time base: field widths, fixed constants
// and event codes. No dependencies.

package pstb_pkg;

    localparam int TIME_W   = 32;               // time, tick and delta width
    localparam int SPEED_W  = 16;               // Q4.12 speed factor
    localparam int FRAC_W   = 12;               // fraction bits of the speed
    localparam int FRAME_W  = 16;               // max frame advance register
    localparam int DEPTH_W  = 8;                // nested stop counter
    localparam int PROD_W   = TIME_W + SPEED_W; // elapsed * speed
    // (product >> 12) + offset needs one carry bit over the shifted product
    localparam int CAND_W   = PROD_W - FRAC_W + 1;
    localparam int DVD_W    = CAND_W + FRAC_W;  // excess << 12
    localparam int REBASE_SHIFT = 18;

    localparam logic [SPEED_W-1:0] SPEED_ONE  = SPEED_W'(4096);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = {DEPTH_W{1'b1}};
    localparam logic [FRAME_W-1:0] FRAME_RST  = FRAME_W'(1000);
    localparam logic [TIME_W-1:0]  SNOW_RST   = TIME_W'(2);
    localparam logic [TIME_W-1:0]  REBASE_SPAN = TIME_W'(1) << REBASE_SHIFT;

    typedef enum logic [2:0] {
        OP_UPDATE = 3'd0,
        OP_STOP   = 3'd1,
        OP_START  = 3'd2,
        OP_SPEED  = 3'd3,
        OP_LOAD   = 3'd4
    } t_op;

endpackage

/* rtl/pausable_scaled_time_base.sv */
// Top level of the pausable scaled time base: event sequencer, clock state
// and result register. Depends on pstb_pkg, pstb_mul and pstb_div.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  event   | i_valid / o_ready, i_op .. i_load_time    | in
//  result  | o_valid / i_ready, o_scaled_time .. stop  | out
//  config  | i_cfg_wr_en, i_cfg_wr_data (max frame)    | in, no wait
//
// One event at a time. Stop, start, speed, load and unused events go from
// the execute state straight to the emit state. An update runs the serial
// multiplier; when the scaled advance is clamped at a nonzero speed, the
// serial divider runs as well. A stopped update skips both. The next event
// is accepted while a result waits in the output register. Reset is
// synchronous, active low.

module pausable_scaled_time_base (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // event channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_op,
    input  logic [pstb_pkg::TIME_W-1:0]       i_now_ticks,
    input  logic [pstb_pkg::SPEED_W-1:0]      i_new_speed,
    input  logic [pstb_pkg::TIME_W-1:0]       i_load_time,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pstb_pkg::TIME_W-1:0]       o_scaled_time,
    output logic [pstb_pkg::TIME_W-1:0]       o_scaled_delta,
    output logic [pstb_pkg::TIME_W-1:0]       o_real_time,
    output logic [pstb_pkg::TIME_W-1:0]       o_real_delta,
    output logic                              o_is_stopped,
    // max frame register
    input  logic                              i_cfg_wr_en,
    input  logic [pstb_pkg::FRAME_W-1:0]      i_cfg_wr_data
);

    localparam int TW = pstb_pkg::TIME_W;
    localparam int CW = pstb_pkg::CAND_W;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_EXEC   = 12'b0000_0000_0010,
        S_MUL    = 12'b0000_0000_0100,
        S_CAND   = 12'b0000_0000_1000,
        S_ADV    = 12'b0000_0001_0000,
        S_CLAMP  = 12'b0000_0010_0000,
        S_DIV    = 12'b0000_0100_0000,
        S_REAL   = 12'b0000_1000_0000,
        S_RADV   = 12'b0001_0000_0000,
        S_RCLAMP = 12'b0010_0000_0000,
        S_CHK    = 12'b0100_0000_0000,
        S_EMIT   = 12'b1000_0000_0000
    } t_state;

    t_state                          r_state;

    // latched event
    logic [2:0]                      r_op;
    logic [TW-1:0]                   r_now;
    logic [pstb_pkg::SPEED_W-1:0]    r_nspd;
    logic [TW-1:0]                   r_ld;

    // clock state
    logic [pstb_pkg::FRAME_W-1:0]    r_maxf;
    logic [TW-1:0]                   r_snow, r_sstep, r_soffset, r_sbase;
    logic [TW-1:0]                   r_rnow, r_rstep, r_roffset, r_rbase;
    logic [pstb_pkg::SPEED_W-1:0]    r_speed;
    logic [pstb_pkg::DEPTH_W-1:0]    r_depth;

    // update scratch
    logic [CW-1:0]                   r_cand;
    logic [CW-1:0]                   r_adv;

    // result register
    logic                            r_ovalid;
    logic [TW-1:0]                   r_o_stime, r_o_sdelta, r_o_rtime, r_o_rdelta;
    logic                            r_o_stop;

    // serial unit handshake and datapath taps
    logic                            n_mul_start;
    logic                            n_div_start;
    logic                            w_mul_done;
    logic                            w_div_done;
    logic [pstb_pkg::PROD_W-1:0]     w_product;
    logic [TW-1:0]                   w_quotient;
    logic [TW-1:0]                   n_elapsed;
    logic [CW:0]                     n_sdiff;
    logic [CW:0]                     n_cdiff;
    logic                            n_sclamp;
    logic [TW-1:0]                   n_maxf32;
    logic                            n_rclamp;
    logic                            n_out_load;

    // combinational helpers
    always_comb begin
        n_maxf32    = {{(TW - pstb_pkg::FRAME_W){1'b0}}, r_maxf};
        n_elapsed   = r_now - r_sbase;
        n_sdiff     = {1'b0, r_cand} - {{(CW - TW + 1){1'b0}}, r_snow};
        n_cdiff     = {1'b0, r_adv} - {{(CW - TW + 1){1'b0}}, n_maxf32};
        n_sclamp    = !n_cdiff[CW] && (n_cdiff[CW-1:0] != '0);
        n_rclamp    = r_adv[TW-1:0] > n_maxf32;
        n_mul_start = (r_state == S_EXEC)
                      && (pstb_pkg::t_op'(r_op) == pstb_pkg::OP_UPDATE)
                      && (r_depth == '0);
        n_div_start = (r_state == S_CLAMP) && n_sclamp && (r_speed != '0);
        n_out_load  = (r_state == S_EMIT) && (!r_ovalid || i_ready);
    end

    pstb_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_mul_start),
        .i_mcand    (n_elapsed),
        .i_mplier   (r_speed),
        .o_done     (w_mul_done),
        .o_product  (w_product)
    );

    pstb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend ({n_cdiff[CW-1:0], {pstb_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_speed),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // event capture
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op   <= i_op;
            r_now  <= i_now_ticks;
            r_nspd <= i_new_speed;
            r_ld   <= i_load_time;
        end
    end

    // sequencer and clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_maxf    <= pstb_pkg::FRAME_RST;
            r_snow    <= pstb_pkg::SNOW_RST;
            r_sstep   <= '0;
            r_soffset <= pstb_pkg::SNOW_RST;
            r_sbase   <= '0;
            r_rnow    <= '0;
            r_rstep   <= '0;
            r_roffset <= '0;
            r_rbase   <= '0;
            r_speed   <= pstb_pkg::SPEED_ONE;
            r_depth   <= '0;
            r_cand    <= '0;
            r_adv     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_maxf <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (pstb_pkg::t_op'(r_op))
                        pstb_pkg::OP_UPDATE: begin
                            r_state <= (r_depth == '0) ? S_MUL : S_REAL;
                        end
                        pstb_pkg::OP_STOP: begin
                            r_state <= S_EMIT;
                            if (r_depth != pstb_pkg::DEPTH_MAX) begin
                                r_depth <= r_depth + pstb_pkg::DEPTH_W'(1);
                            end
                        end
                        pstb_pkg::OP_START: begin
                            r_state <= S_EMIT;
                            if (r_depth == pstb_pkg::DEPTH_W'(1)) begin
                                r_soffset <= r_snow;
                                r_sbase   <= r_now;
                            end
                            if (r_depth != '0) begin
                                r_depth <= r_depth - pstb_pkg::DEPTH_W'(1);
                            end
                        end
                        pstb_pkg::OP_SPEED: begin
                            r_state   <= S_EMIT;
                            r_soffset <= r_snow;
                            r_roffset <= r_rnow;
                            r_sbase   <= r_now;
                            r_rbase   <= r_now;
                            r_speed   <= r_nspd;
                        end
                        pstb_pkg::OP_LOAD: begin
                            r_state   <= S_EMIT;
                            r_snow    <= r_ld;
                            r_rnow    <= r_ld;
                            r_soffset <= r_ld;
                            r_roffset <= r_ld;
                            r_sbase   <= r_now;
                            r_rbase   <= r_now;
                            r_speed   <= pstb_pkg::SPEED_ONE;
                        end
                        default: begin
                            // unused codes report the current values
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_CAND;
                    end
                end
                // scaled candidate = (product >> 12) + offset
                S_CAND: begin
                    r_cand  <= {1'b0, w_product[pstb_pkg::PROD_W-1:pstb_pkg::FRAC_W]}
                               + {{(CW - TW){1'b0}}, r_soffset};
                    r_state <= S_ADV;
                end
                // time running backwards rebases and holds the scaled clock
                S_ADV: begin
                    if (n_sdiff[CW]) begin
                        r_soffset <= r_snow;
                        r_roffset <= r_rnow;
                        r_sbase   <= r_now;
                        r_rbase   <= r_now;
                        r_cand    <= {{(CW - TW){1'b0}}, r_snow};
                        r_adv     <= '0;
                    end else begin
                        r_adv <= n_sdiff[CW-1:0];
                    end
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (n_sclamp) begin
                        r_snow  <= r_snow + n_maxf32;
                        r_sstep <= n_maxf32;
                        r_state <= (r_speed != '0) ? S_DIV : S_REAL;
                    end else begin
                        r_snow  <= r_cand[TW-1:0];
                        r_sstep <= r_adv[TW-1:0];
                        r_state <= S_REAL;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_sbase <= r_sbase + w_quotient;
                        r_state <= S_REAL;
                    end
                end
                // real clock, all modulo 2^32
                S_REAL: begin
                    r_cand  <= {{(CW - TW){1'b0}}, r_now - r_rbase + r_roffset};
                    r_state <= S_RADV;
                end
                S_RADV: begin
                    r_adv   <= {{(CW - TW){1'b0}}, r_cand[TW-1:0] - r_rnow};
                    r_state <= S_RCLAMP;
                end
                S_RCLAMP: begin
                    if (n_rclamp) begin
                        r_rbase <= r_rbase + r_adv[TW-1:0] - n_maxf32;
                        r_rnow  <= r_rnow + n_maxf32;
                        r_rstep <= n_maxf32;
                    end else begin
                        r_rnow  <= r_cand[TW-1:0];
                        r_rstep <= r_adv[TW-1:0];
                    end
                    r_state <= S_CHK;
                end
                // scaled clock too far from its base: rebase
                S_CHK: begin
                    if (r_snow > r_sbase + pstb_pkg::REBASE_SPAN) begin
                        r_soffset <= r_snow;
                        r_roffset <= r_rnow;
                        r_sbase   <= r_now;
                        r_rbase   <= r_now;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (n_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (n_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_o_stime  <= r_snow;
            r_o_sdelta <= r_sstep;
            r_o_rtime  <= r_rnow;
            r_o_rdelta <= r_rstep;
            r_o_stop   <= (r_depth != '0);
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_scaled_time  = r_o_stime;
    assign o_scaled_delta = r_o_sdelta;
    assign o_real_time    = r_o_rtime;
    assign o_real_delta   = r_o_rdelta;
    assign o_is_stopped   = r_o_stop;

`ifndef SYNTHESIS
    // one event at a time: an accepted transaction closes the event side
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("event accepted while another is in flight");

    // the divider never runs with a zero speed
    a_div_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_div_start |-> (r_speed != '0))
        else $error("divider started with zero speed");

    // stop count saturates
    a_stop_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (pstb_pkg::t_op'(r_op) == pstb_pkg::OP_STOP)
         && (r_depth == pstb_pkg::DEPTH_MAX)) |=> (r_depth == pstb_pkg::DEPTH_MAX))
        else $error("stop count wrapped");

    // a result appears only from the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside the emit step");
`endif

endmodule

/* rtl/pstb_mul.sv */
// Serial shift-add multiplier: 32-bit elapsed ticks times Q4.12 speed,
// one multiplier bit per cycle. Depends on pstb_pkg.

module pstb_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pstb_pkg::TIME_W-1:0]       i_mcand,
    input  logic [pstb_pkg::SPEED_W-1:0]      i_mplier,
    output logic                              o_done,
    output logic [pstb_pkg::PROD_W-1:0]       o_product
);

    localparam int CNT_W = $clog2(pstb_pkg::SPEED_W);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [pstb_pkg::TIME_W-1:0]     r_mcand;
    // upper part accumulates, lower part shifts out the multiplier bits
    logic [pstb_pkg::PROD_W-1:0]     r_acc;
    logic [pstb_pkg::TIME_W:0]       n_sum;

    // partial product add on the upper part
    always_comb begin
        n_sum = {1'b0, r_acc[pstb_pkg::PROD_W-1:pstb_pkg::SPEED_W]};
        if (r_acc[0]) begin
            n_sum = n_sum + {1'b0, r_mcand};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(pstb_pkg::SPEED_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_acc   <= {{pstb_pkg::TIME_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_acc <= {n_sum, r_acc[pstb_pkg::SPEED_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

/* rtl/pstb_div.sv */
// Serial restoring divider for the base correction: (excess << 12) / speed,
// one quotient bit per cycle. Depends on pstb_pkg.

module pstb_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pstb_pkg::DVD_W-1:0]        i_dividend,
    input  logic [pstb_pkg::SPEED_W-1:0]      i_divisor,
    output logic                              o_done,
    output logic [pstb_pkg::TIME_W-1:0]       o_quotient
);

    localparam int CNT_W = $clog2(pstb_pkg::DVD_W);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [pstb_pkg::SPEED_W-1:0]    r_divisor;
    logic [pstb_pkg::SPEED_W-1:0]    r_rem;
    // dividend bits leave at the top, quotient bits enter at the bottom
    logic [pstb_pkg::DVD_W-1:0]      r_qd;
    logic [pstb_pkg::SPEED_W:0]      n_trial;
    logic [pstb_pkg::SPEED_W:0]      n_diff;
    logic                            n_qbit;

    // trial subtract
    always_comb begin
        n_trial = {r_rem, r_qd[pstb_pkg::DVD_W-1]};
        n_diff  = n_trial - {1'b0, r_divisor};
        n_qbit  = (n_trial >= {1'b0, r_divisor});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(pstb_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath; remainder stays below the divisor, so 16 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_qd      <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_qbit ? n_diff[pstb_pkg::SPEED_W-1:0]
                            : n_trial[pstb_pkg::SPEED_W-1:0];
            r_qd  <= {r_qd[pstb_pkg::DVD_W-2:0], n_qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_qd[pstb_pkg::TIME_W-1:0];

endmodule

/* verif/tb_pausable_scaled_time_base.sv */
`timescale 1ns / 1ps
// Testbench for pausable_scaled_time_base: directed and random event traffic,
// with the result of each event checked against an in-bench clock predictor.
// Depends on pstb_pkg and the RTL of the time base.

module tb_pausable_scaled_time_base;

    // Clock, reset and DUT ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [2:0]                    i_op = pstb_pkg::OP_UPDATE;
    logic [pstb_pkg::TIME_W-1:0]   i_now_ticks = '0;
    logic [pstb_pkg::SPEED_W-1:0]  i_new_speed = '0;
    logic [pstb_pkg::TIME_W-1:0]   i_load_time = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [pstb_pkg::TIME_W-1:0]   o_scaled_time;
    logic [pstb_pkg::TIME_W-1:0]   o_scaled_delta;
    logic [pstb_pkg::TIME_W-1:0]   o_real_time;
    logic [pstb_pkg::TIME_W-1:0]   o_real_delta;
    logic                          o_is_stopped;
    logic                          i_cfg_wr_en = 1'b0;
    logic [pstb_pkg::FRAME_W-1:0]  i_cfg_wr_data = '0;

    // Opcodes the block does not define; they must leave all state alone
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef struct {
        logic [pstb_pkg::TIME_W-1:0] scaled_time;
        logic [pstb_pkg::TIME_W-1:0] scaled_delta;
        logic [pstb_pkg::TIME_W-1:0] real_time;
        logic [pstb_pkg::TIME_W-1:0] real_delta;
        logic                        is_stopped;
    } t_clock_report;

    t_clock_report expected_reports[$];

    // Predicted clock state
    logic [pstb_pkg::TIME_W-1:0]  sc_now, sc_step, sc_off, sc_base;
    logic [pstb_pkg::TIME_W-1:0]  rl_now, rl_step, rl_off, rl_base;
    logic [pstb_pkg::SPEED_W-1:0] spd_q412;
    logic [pstb_pkg::DEPTH_W-1:0] stop_cnt;
    logic [pstb_pkg::FRAME_W-1:0] frame_cap;

    // Run bookkeeping
    int          fail_cnt = 0;
    int          events_sent = 0;
    int          reports_checked = 0;
    int          cap_writes = 0;
    int          ready_hold = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    logic [31:0] tick_now = '0;

    pausable_scaled_time_base uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_now_ticks    (i_now_ticks),
        .i_new_speed    (i_new_speed),
        .i_load_time    (i_load_time),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_scaled_time  (o_scaled_time),
        .o_scaled_delta (o_scaled_delta),
        .o_real_time    (o_real_time),
        .o_real_delta   (o_real_delta),
        .o_is_stopped   (o_is_stopped),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Clock predictor
    // ------------------------------------------------------------------

    function automatic void clear_clocks();
        frame_cap = pstb_pkg::FRAME_RST;
        sc_now    = pstb_pkg::SNOW_RST;
        sc_step   = '0;
        sc_off    = pstb_pkg::SNOW_RST;
        sc_base   = '0;
        rl_now    = '0;
        rl_step   = '0;
        rl_off    = '0;
        rl_base   = '0;
        spd_q412  = pstb_pkg::SPEED_ONE;
        stop_cnt  = '0;
    endfunction

    // Both clocks restart from their current times at tick count now
    function automatic void rebase_clocks(input logic [pstb_pkg::TIME_W-1:0] now);
        sc_off  = sc_now;
        rl_off  = rl_now;
        sc_base = now;
        rl_base = now;
    endfunction

    // Frame update of both clocks with clamping and rebasing
    function automatic void advance_clocks(input logic [pstb_pkg::TIME_W-1:0] now);
        logic [pstb_pkg::TIME_W-1:0] elapsed;
        logic [63:0]                 cand;
        logic [63:0]                 adv;
        logic [63:0]                 extra;
        logic [pstb_pkg::TIME_W-1:0] rcand;
        logic [pstb_pkg::TIME_W-1:0] radv;

        // scaled clock only runs when not stopped
        if (stop_cnt == '0) begin
            elapsed = now - sc_base;
            cand = ((64'(elapsed) * 64'(spd_q412)) >> pstb_pkg::FRAC_W) + 64'(sc_off);
            if (cand < 64'(sc_now)) begin
                rebase_clocks(now);
                cand = 64'(sc_now);
            end
            adv = cand - 64'(sc_now);
            if (adv > 64'(frame_cap)) begin
                // push the base forward for the clamped excess
                if (spd_q412 != '0) begin
                    extra = ((adv - 64'(frame_cap)) << pstb_pkg::FRAC_W)
                            / 64'(spd_q412);
                    sc_base = sc_base + extra[pstb_pkg::TIME_W-1:0];
                end
                cand = 64'(sc_now) + 64'(frame_cap);
                adv  = 64'(frame_cap);
            end
            sc_step = adv[pstb_pkg::TIME_W-1:0];
            sc_now  = cand[pstb_pkg::TIME_W-1:0];
        end

        // real clock, modulo 2^32 throughout
        rcand = now - rl_base + rl_off;
        radv  = rcand - rl_now;
        if (radv > 32'(frame_cap)) begin
            rl_base = rl_base + (radv - 32'(frame_cap));
            rcand   = rl_now + 32'(frame_cap);
            radv    = 32'(frame_cap);
        end
        rl_step = radv;
        rl_now  = rcand;

        // too far from the base: rebase
        if (sc_now > sc_base + pstb_pkg::REBASE_SPAN)
            rebase_clocks(now);
    endfunction

    // Apply one event to the predictor and return the report it yields
    function automatic t_clock_report apply_event(
        input logic [2:0]                   op,
        input logic [pstb_pkg::TIME_W-1:0]  now,
        input logic [pstb_pkg::SPEED_W-1:0] spd,
        input logic [pstb_pkg::TIME_W-1:0]  ld);
        t_clock_report rpt;

        unique case (op)
            pstb_pkg::OP_UPDATE: begin
                advance_clocks(now);
            end
            pstb_pkg::OP_STOP: begin
                if (stop_cnt != pstb_pkg::DEPTH_MAX)
                    stop_cnt = stop_cnt + pstb_pkg::DEPTH_W'(1);
            end
            pstb_pkg::OP_START: begin
                if (stop_cnt == pstb_pkg::DEPTH_W'(1)) begin
                    sc_off  = sc_now;
                    sc_base = now;
                end
                if (stop_cnt != '0)
                    stop_cnt = stop_cnt - pstb_pkg::DEPTH_W'(1);
            end
            pstb_pkg::OP_SPEED: begin
                rebase_clocks(now);
                spd_q412 = spd;
            end
            pstb_pkg::OP_LOAD: begin
                sc_now = ld;
                rl_now = ld;
                rebase_clocks(now);
                spd_q412 = pstb_pkg::SPEED_ONE;
            end
            default: begin
            end
        endcase

        rpt.scaled_time  = sc_now;
        rpt.scaled_delta = sc_step;
        rpt.real_time    = rl_now;
        rpt.real_delta   = rl_step;
        rpt.is_stopped   = (stop_cnt != '0);
        return rpt;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_clock_report want;

        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                reports_checked++;
                if (expected_reports.size() == 0) begin
                    $error("result transaction with no event pending");
                    fail_cnt++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_scaled_time !== want.scaled_time) begin
                        $error("scaled_time: expected %0d, got %0d",
                               want.scaled_time, o_scaled_time);
                        fail_cnt++;
                    end
                    if (o_scaled_delta !== want.scaled_delta) begin
                        $error("scaled_delta: expected %0d, got %0d",
                               want.scaled_delta, o_scaled_delta);
                        fail_cnt++;
                    end
                    if (o_real_time !== want.real_time) begin
                        $error("real_time: expected %0d, got %0d",
                               want.real_time, o_real_time);
                        fail_cnt++;
                    end
                    if (o_real_delta !== want.real_delta) begin
                        $error("real_delta: expected %0d, got %0d",
                               want.real_delta, o_real_delta);
                        fail_cnt++;
                    end
                    if (o_is_stopped !== want.is_stopped) begin
                        $error("is_stopped: expected %0b, got %0b",
                               want.is_stopped, o_is_stopped);
                        fail_cnt++;
                    end
                end
                ready_hold = recv_calm ? 0 : $urandom_range(0, 19);
            end else if (ready_hold != 0) begin
                ready_hold--;
            end
            i_ready <= (ready_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Event side
    // ------------------------------------------------------------------

    // One event transaction; valid is left high so back-to-back events
    // never drop it in between
    task automatic send_event(input logic [2:0] op,
                              input logic [pstb_pkg::TIME_W-1:0] now,
                              input logic [pstb_pkg::SPEED_W-1:0] spd,
                              input logic [pstb_pkg::TIME_W-1:0] ld);
        int gap;

        gap = send_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        expected_reports.push_back(apply_event(op, now, spd, ld));
        events_sent++;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_now_ticks <= now;
        i_new_speed <= spd;
        i_load_time <= ld;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with nothing in flight
    task automatic write_frame_cap(input logic [pstb_pkg::FRAME_W-1:0] cap);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        frame_cap = cap;
        cap_writes++;
    endtask

    task automatic send_update(input logic [pstb_pkg::TIME_W-1:0] now);
        tick_now = now;
        send_event(pstb_pkg::OP_UPDATE, now, pstb_pkg::SPEED_W'($urandom), $urandom);
    endtask

    // Mostly frame-sized steps, with some long gaps, jumps back and wild values
    function automatic logic [31:0] next_tick();
        int r;

        r = $urandom_range(0, 99);
        if (r < 70)
            tick_now = tick_now + $urandom_range(0, 40);
        else if (r < 85)
            tick_now = tick_now + $urandom_range(41, 3000);
        else if (r < 90)
            tick_now = tick_now + $urandom_range(3001, 400000);
        else if (r < 95)
            tick_now = tick_now - $urandom_range(1, 5000);
        else
            tick_now = $urandom;
        return tick_now;
    endfunction

    function automatic logic [pstb_pkg::SPEED_W-1:0] pick_speed();
        int r;

        r = $urandom_range(0, 99);
        if (r < 15)      return '0;
        else if (r < 35) return pstb_pkg::SPEED_ONE;
        else if (r < 45) return '1;
        else if (r < 75) return pstb_pkg::SPEED_W'($urandom_range(1, 8192));
        else             return pstb_pkg::SPEED_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [pstb_pkg::TIME_W-1:0] pick_load();
        int r;

        r = $urandom_range(0, 2);
        if (r == 0)      return $urandom;
        else if (r == 1) return $urandom_range(0, 1000);
        else             return 32'hFFFF_FFFF - $urandom_range(0, 2000);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation and the corner cases, in a fixed order
    task automatic test_directed_events();
        send_update(32'd16);
        send_update(32'd40);
        send_update(32'd5000);                 // clamp with base shift
        send_update(32'd3000);                 // time runs backwards
        send_event(pstb_pkg::OP_STOP, 32'd3010, '0, '0);
        send_event(pstb_pkg::OP_STOP, 32'd3020, '0, '0); // nested
        send_update(32'd3100);                 // stopped: only real clock moves
        send_event(pstb_pkg::OP_START, 32'd3110, '0, '0);
        send_event(pstb_pkg::OP_START, 32'd3120, '0, '0); // last start restarts
        send_event(pstb_pkg::OP_START, 32'd3130, '0, '0); // already running
        send_event(pstb_pkg::OP_SPEED, 32'd3200, '0, '0);
        send_update(32'd9000);                 // zero speed, real clamps
        send_event(pstb_pkg::OP_SPEED, 32'd9010, '1, '0);
        send_update(32'd9020);
        send_update(32'hFFFF_FFF0);
        send_update(32'h0000_0010);            // counter wraps
        send_event(pstb_pkg::OP_LOAD, 32'd100, '0, 32'hFFFF_FFFF);
        send_update(32'd120);
        send_event(pstb_pkg::OP_LOAD, 32'hFFFF_FFFF, 16'h5A5A, 32'h0);
        send_update(32'd5);
        send_event(OP_SPARE_A, $urandom, pstb_pkg::SPEED_W'($urandom), $urandom);
        send_event(OP_SPARE_B, $urandom, pstb_pkg::SPEED_W'($urandom), $urandom);
        send_event(OP_SPARE_C, $urandom, pstb_pkg::SPEED_W'($urandom), $urandom);
        // zero max frame clamps every advance
        write_frame_cap('0);
        send_update(32'd60);
        send_update(32'd900);
        write_frame_cap(pstb_pkg::FRAME_RST);
    endtask

    // Stop count saturates at its maximum, so one fewer start clears it
    task automatic test_stop_saturation();
        repeat (int'(pstb_pkg::DEPTH_MAX) + 1)
            send_event(pstb_pkg::OP_STOP, next_tick(), '0, '0);
        send_update(next_tick());
        repeat (int'(pstb_pkg::DEPTH_MAX))
            send_event(pstb_pkg::OP_START, next_tick(), '0, '0);
        send_update(next_tick());
    endtask

    // Random event mix at one max-frame setting
    task automatic test_random_traffic(input int n_items,
                                       input logic [pstb_pkg::FRAME_W-1:0] cap);
        int done;
        int r;

        write_frame_cap(cap);
        done = 0;
        while (done < n_items) begin
            // occasionally switch to back-to-back traffic on either side
            if (done % 64 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                send_update(next_tick());
            else if (r < 70)
                send_event(pstb_pkg::OP_STOP, next_tick(),
                           pstb_pkg::SPEED_W'($urandom), $urandom);
            else if (r < 80)
                send_event(pstb_pkg::OP_START, next_tick(),
                           pstb_pkg::SPEED_W'($urandom), $urandom);
            else if (r < 88)
                send_event(pstb_pkg::OP_SPEED, next_tick(), pick_speed(), $urandom);
            else if (r < 97)
                send_event(pstb_pkg::OP_LOAD, next_tick(),
                           pstb_pkg::SPEED_W'($urandom), pick_load());
            else begin
                // noise: spare opcode, not counted
                send_event(3'($urandom_range(5, 7)), $urandom,
                           pstb_pkg::SPEED_W'($urandom), $urandom);
                continue;
            end
            done++;
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    // Run limit
    initial begin
        #20ms;
        $display("tb_pausable_scaled_time_base NOT OK");
        $finish;
    end

    initial begin
        clear_clocks();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_events();
        test_stop_saturation();
        test_random_traffic(160, pstb_pkg::FRAME_RST);
        test_random_traffic(160, pstb_pkg::FRAME_W'(1));
        test_random_traffic(160, '1);
        test_random_traffic(160, pstb_pkg::FRAME_W'(16));
        test_random_traffic(160, '0);
        test_random_traffic(160, pstb_pkg::FRAME_W'($urandom_range(1, 65535)));

        // drain, then leave room for any stray result
        wait_idle();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d events and %0d checked results across %0d max-frame writes,",
                 events_sent, reports_checked, cap_writes);
        $display("including nested stops, speed changes, time loads and spare opcodes.");
        if (fail_cnt == 0)
            $display("tb_pausable_scaled_time_base OK");
        else
            $display("tb_pausable_scaled_time_base NOT OK");
        $finish;
    end

endmodule
